@@ rtl/ita_pkg.sv @@
// Package: shared constants and types for the IPv6 text address parser.
package ita_pkg;

   localparam int NUM_GROUPS = 8;
   localparam int MAX_DIGITS = 4;
   localparam int GROUP_BITS = 16;
   localparam int GROUP_IDX_W = 3;
   localparam int GROUP_CNT_W = 4;
   localparam int DIGIT_CNT_W = 3;
   localparam logic [7:0] COLON_CHAR = 8'h3A;

   typedef logic [GROUP_BITS-1:0] group_type;
   typedef logic [GROUP_CNT_W-1:0] group_cnt_type;

   // Character class produced by the front end
   typedef enum logic [1:0] {
      TOK_HEX,
      TOK_COLON,
      TOK_BAD
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [3:0]   digit;
      logic         last;
   } token_type;

endpackage

@@ rtl/ita_if.sv @@
// Interfaces: request (character) and response (address) stream channels.
interface ita_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       last_char;

   modport source (output valid, text_char, last_char, input ready);
   modport sink   (input valid, text_char, last_char, output ready);
endinterface

interface ita_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] addr_high;
   logic [63:0] addr_low;
   logic        addr_valid;

   modport source (output valid, addr_high, addr_low, addr_valid, input ready);
   modport sink   (input valid, addr_high, addr_low, addr_valid, output ready);
endinterface

@@ rtl/ipv6_text_address_parser_unit.sv @@
// Top level: IPv6 text address parser, character stream in, 128-bit address out.
//
// The block takes one character of an IPv6 address per cycle on req_chan
// while the token queue has room and, for the character marked last, delivers
// one result on rsp_chan: the address as two 64-bit halves and a flag that is 1
// for well-formed text (invalid text gives zero halves). Sustained rate is one
// character per cycle, set by the back-end parse state that absorbs one token
// each cycle unless a last token waits on a held snapshot while rsp_chan stalls;
// a following address may start in the cycle after a last character. A front
// end classifies each character into a two-entry token queue; the back end
// updates the running group state, then expands the double-colon gap in a second
// stage and holds the result in an output register.
module ipv6_text_address_parser_unit
   import ita_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ita_req_if.sink   req_chan,
   ita_rsp_if.source rsp_chan
);

   logic      push_valid, push_ready;
   token_type push_tok;
   logic      pop_valid, pop_ready;
   token_type pop_tok;

   ita_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_tok   (push_tok)
   );

   ita_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_tok   (push_tok),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_tok    (pop_tok)
   );

   ita_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (pop_valid),
      .tok_ready (pop_ready),
      .tok       (pop_tok),
      .rsp_chan  (rsp_chan)
   );

   // An invalid result never carries address bits
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.addr_valid |->
         rsp_chan.addr_high == 64'd0 && rsp_chan.addr_low == 64'd0)
      else $error("invalid result with nonzero address");

   // A rising result follows a last token taken by the back end, through the snapshot and output registers
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(pop_valid && pop_ready && pop_tok.last, 2))
      else $error("result without a preceding last character");

   // Queue full stalls the request channel
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !push_ready |-> pop_valid && !req_chan.ready)
      else $error("request accepted while token queue full");

endmodule

@@ rtl/ita_front.sv @@
// Front end: accepts characters and classifies them into tokens.
module ita_front
   import ita_pkg::*;
(
   ita_req_if.sink    req_chan,
   output logic       push_valid,
   input  logic       push_ready,
   output token_type  push_tok
);

   logic [7:0] ch;

   assign ch                 = req_chan.text_char;
   assign push_valid         = req_chan.valid;
   assign req_chan.ready     = push_ready;

   // Character class and hex digit value
   always_comb begin
      push_tok.last  = req_chan.last_char;
      push_tok.kind  = TOK_BAD;
      push_tok.digit = 4'd0;
      if (ch == COLON_CHAR) begin
         push_tok.kind = TOK_COLON;
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         push_tok.kind  = TOK_HEX;
         push_tok.digit = 4'(ch - 8'h30);
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         push_tok.kind  = TOK_HEX;
         push_tok.digit = 4'(ch - 8'h41 + 8'd10);
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         push_tok.kind  = TOK_HEX;
         push_tok.digit = 4'(ch - 8'h61 + 8'd10);
      end
   end

endmodule

@@ rtl/ita_fifo.sv @@
// Two-entry token queue between front end and back end.
module ita_fifo
   import ita_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  token_type push_tok,
   output logic      pop_valid,
   input  logic      pop_ready,
   output token_type pop_tok
);

   token_type  mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_tok    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_tok;
      end
   end

endmodule

@@ rtl/ita_back.sv @@
// Back end: running parse state, gap expansion stage and output register.
module ita_back
   import ita_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       tok_valid,
   output logic       tok_ready,
   input  token_type  tok,
   ita_rsp_if.source  rsp_chan
);

   // Running parse state
   group_type                store_ff [NUM_GROUPS];
   group_type                store_in [NUM_GROUPS];
   group_cnt_type            cnt_ff, cnt_in;
   group_type                cur_ff, cur_in;
   logic [DIGIT_CNT_W-1:0]   dc_ff, dc_in;
   logic                     gap_ff, gap_in;
   group_cnt_type            gpos_ff, gpos_in;
   logic                     pc_ff, pc_in;
   logic                     err_ff, err_in;

   // Finished-address snapshot
   group_type                snap_store_ff [NUM_GROUPS];
   group_cnt_type            snap_fill_ff, snap_fill_in;
   group_cnt_type            snap_gp_ff, snap_gp_in;
   logic                     snap_ok_ff;
   logic                     snap_valid_ff;

   // Output register
   logic                     out_valid_ff;
   logic [63:0]              out_high_ff, out_high_in;
   logic [63:0]              out_low_ff, out_low_in;
   logic                     out_ok_ff;

   logic                     take, finish, snap_move, snap_free, out_free;

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign snap_move = snap_valid_ff && out_free;
   assign snap_free = !snap_valid_ff || snap_move;
   assign tok_ready = !tok.last || snap_free;
   assign take      = tok_valid && tok_ready;
   assign finish    = take && tok.last;

   // Token update and end-of-address checks
   always_comb begin
      store_in = store_ff;
      cnt_in   = cnt_ff;
      cur_in   = cur_ff;
      dc_in    = dc_ff;
      gap_in   = gap_ff;
      gpos_in  = gpos_ff;
      pc_in    = pc_ff;
      err_in   = err_ff;
      if (take && !err_in) begin
         unique case (tok.kind)
            TOK_COLON: begin
               if (dc_in != '0) begin
                  if (cnt_in >= group_cnt_type'(NUM_GROUPS)) begin
                     err_in = 1'b1;
                  end else begin
                     store_in[cnt_in[GROUP_IDX_W-1:0]] = cur_in;
                     cnt_in = cnt_in + 1'b1;
                  end
                  cur_in = '0;
                  dc_in  = '0;
                  pc_in  = 1'b1;
               end else if (pc_in) begin
                  if (gap_in) begin
                     err_in = 1'b1;
                  end else begin
                     gap_in  = 1'b1;
                     gpos_in = cnt_in;
                     pc_in   = 1'b0;
                  end
               end else if (cnt_in == '0 && !gap_in) begin
                  pc_in = 1'b1;
               end else begin
                  err_in = 1'b1;
               end
            end
            TOK_HEX: begin
               if (pc_in && cnt_in == '0 && !gap_in) begin
                  err_in = 1'b1;
               end else if (dc_in >= DIGIT_CNT_W'(MAX_DIGITS)) begin
                  err_in = 1'b1;
               end else begin
                  cur_in = {cur_in[GROUP_BITS-5:0], tok.digit};
                  dc_in  = dc_in + 1'b1;
                  pc_in  = 1'b0;
               end
            end
            default: begin
               err_in = 1'b1;
            end
         endcase
      end
      if (finish && !err_in) begin
         if (dc_in != '0) begin
            if (cnt_in >= group_cnt_type'(NUM_GROUPS)) begin
               err_in = 1'b1;
            end else begin
               store_in[cnt_in[GROUP_IDX_W-1:0]] = cur_in;
               cnt_in = cnt_in + 1'b1;
            end
         end else if (pc_in) begin
            err_in = 1'b1;
         end
      end
      if (finish && !err_in) begin
         if (gap_in && cnt_in >= group_cnt_type'(NUM_GROUPS)) begin
            err_in = 1'b1;
         end
         if (!gap_in && cnt_in != group_cnt_type'(NUM_GROUPS)) begin
            err_in = 1'b1;
         end
      end
      snap_fill_in = gap_in ? group_cnt_type'(NUM_GROUPS) - cnt_in : '0;
      snap_gp_in   = gap_in ? gpos_in : group_cnt_type'(NUM_GROUPS);
   end

   // Parse state registers; cleared after the last character
   always_ff @(posedge clock) begin
      if (reset || finish) begin
         cnt_ff  <= '0;
         cur_ff  <= '0;
         dc_ff   <= '0;
         gap_ff  <= 1'b0;
         gpos_ff <= '0;
         pc_ff   <= 1'b0;
         err_ff  <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         cur_ff  <= cur_in;
         dc_ff   <= dc_in;
         gap_ff  <= gap_in;
         gpos_ff <= gpos_in;
         pc_ff   <= pc_in;
         err_ff  <= err_in;
      end
   end

   // Group store; only entries below the group count are ever read
   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   // Snapshot of a finished address
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (snap_free) begin
         snap_valid_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         snap_store_ff <= store_in;
         snap_fill_ff  <= snap_fill_in;
         snap_gp_ff    <= snap_gp_in;
         snap_ok_ff    <= !err_in;
      end
   end

   // Gap expansion into the two address halves
   always_comb begin
      group_type     g;
      group_cnt_type idx;
      group_cnt_type src;
      out_high_in = '0;
      out_low_in  = '0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
         idx = group_cnt_type'(i);
         src = idx - snap_fill_ff;
         g   = '0;
         if (idx < snap_gp_ff) begin
            g = snap_store_ff[idx[GROUP_IDX_W-1:0]];
         end else if (idx >= snap_gp_ff + snap_fill_ff) begin
            g = snap_store_ff[src[GROUP_IDX_W-1:0]];
         end
         if (!snap_ok_ff) begin
            g = '0;
         end
         if (i < NUM_GROUPS / 2) begin
            out_high_in[(NUM_GROUPS/2-1-i)*GROUP_BITS +: GROUP_BITS] = g;
         end else begin
            out_low_in[(NUM_GROUPS-1-i)*GROUP_BITS +: GROUP_BITS] = g;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_move) begin
         out_high_ff <= out_high_in;
         out_low_ff  <= out_low_in;
         out_ok_ff   <= snap_ok_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.addr_high  = out_high_ff;
   assign rsp_chan.addr_low   = out_low_ff;
   assign rsp_chan.addr_valid = out_ok_ff;

endmodule
